// ===== hw/rtl/sha1sh_pkg.sv =====
// Shared types, constants and state encodings for the SHA-1 stream hash core.
package sha1sh_pkg;

    localparam int QDEPTH = 16;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [3:0] WORD_LEN_HI = 4'd14;
    localparam logic [6:0] ROUND_LOAD_LAST = 7'd15;
    localparam logic [6:0] ROUND_LAST      = 7'd79;
    localparam logic [2:0] DIGEST_LAST     = 3'd4;

    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };
    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } t_qentry;

    typedef struct packed {
        logic    valid;
        t_qentry entry;
    } t_qpush;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    typedef enum logic [2:0] {
        F_ACCEPT,
        F_PAD,
        F_ZERO,
        F_LENHI,
        F_LENLO
    } t_fstate;

    typedef enum logic [1:0] {
        B_LOAD,
        B_ROUND,
        B_ADD,
        B_EMIT
    } t_bstate;

endpackage

// ===== hw/rtl/sha1sh_front.sv =====
// Front end: packs bytes into big-endian words, counts bytes, generates padding and length.
module sha1sh_front
    import sha1sh_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    input  t_qstat   i_qstat,
    output t_qpush   o_push
);

    t_fstate     r_state, n_state;
    logic [60:0] r_count, n_count;
    logic [23:0] r_part, n_part;
    logic [3:0]  r_widx, n_widx;
    logic        w_acc;
    logic [31:0] w_pad_word;

    assign w_acc = i_in_valid && o_in_ready;

    always_comb begin
        unique case (r_count[1:0])
            2'd0: w_pad_word = {PAD_BYTE, 24'h0};
            2'd1: w_pad_word = {r_part[7:0], PAD_BYTE, 16'h0};
            2'd2: w_pad_word = {r_part[15:0], PAD_BYTE, 8'h0};
            default: w_pad_word = {r_part[23:0], PAD_BYTE};
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_ACCEPT: if (w_acc && i_in_data.end_of_message) n_state = F_PAD;
            F_PAD:    if (!i_qstat.full) n_state = F_ZERO;
            F_ZERO:   if (r_widx == WORD_LEN_HI) n_state = F_LENHI;
            F_LENHI:  if (!i_qstat.full) n_state = F_LENLO;
            F_LENLO:  if (!i_qstat.full) n_state = F_ACCEPT;
            default:  n_state = F_ACCEPT;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready        = 1'b0;
        o_push.valid      = 1'b0;
        o_push.entry.word = '0;
        o_push.entry.last = 1'b0;
        unique case (r_state)
            F_ACCEPT: begin
                o_in_ready        = !i_qstat.full;
                o_push.valid      = w_acc && i_in_data.byte_valid && (r_count[1:0] == 2'd3);
                o_push.entry.word = {r_part, i_in_data.data_byte};
            end
            F_PAD: begin
                o_push.valid      = !i_qstat.full;
                o_push.entry.word = w_pad_word;
            end
            F_ZERO: begin
                o_push.valid = !i_qstat.full && (r_widx != WORD_LEN_HI);
            end
            F_LENHI: begin
                o_push.valid      = !i_qstat.full;
                o_push.entry.word = r_count[60:29];
            end
            F_LENLO: begin
                o_push.valid      = !i_qstat.full;
                o_push.entry.word = {r_count[28:0], 3'b000};
                o_push.entry.last = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_part  = r_part;
        n_widx  = r_widx;
        unique case (r_state)
            F_ACCEPT: begin
                if (w_acc && i_in_data.byte_valid) begin
                    n_count = r_count + 61'd1;
                    n_part  = {r_part[15:0], i_in_data.data_byte};
                end
            end
            F_PAD:    if (o_push.valid) n_widx = r_count[5:2] + 4'd1;
            F_ZERO:   if (o_push.valid) n_widx = r_widx + 4'd1;
            F_LENLO:  if (o_push.valid) n_count = '0;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_ACCEPT;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_part <= n_part;
        r_widx <= n_widx;
    end

endmodule

// ===== hw/rtl/sha1sh_queue.sv =====
// Word queue between the front end and the compression engine.
module sha1sh_queue
    import sha1sh_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_qpush  i_push,
    input  logic    i_pop,
    output t_qentry o_head,
    output t_qstat  o_stat
);

    t_qentry        r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QAW:0]   r_cnt;

    assign o_head       = r_mem[r_rd];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == (QAW+1)'(QDEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push.valid) r_mem[r_wr] <= i_push.entry;
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.valid) r_wr <= r_wr + 1'b1;
            if (i_pop)        r_rd <= r_rd + 1'b1;
            if (i_push.valid && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push.valid && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// ===== hw/rtl/sha1sh_back.sv =====
// Compression: one SHA-1 round per cycle if fed; rolling schedule, hash add, digest out.
module sha1sh_back
    import sha1sh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_qentry   i_head,
    input  t_qstat    i_qstat,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_bstate     r_state, n_state;
    logic [6:0]  r_t;
    logic [2:0]  r_idx;
    logic        r_fin;
    logic [31:0] r_hash [5];
    logic [31:0] r_work [5];
    logic [31:0] r_sched [16];

    logic        w_round, w_out_acc;
    logic [31:0] w_a, w_b, w_c, w_d, w_e, w_f, w_k, w_w, w_x, w_tmp;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_LOAD:  if (!i_qstat.empty && r_t == ROUND_LOAD_LAST) n_state = B_ROUND;
            B_ROUND: if (r_t == ROUND_LAST) n_state = B_ADD;
            B_ADD:   n_state = r_fin ? B_EMIT : B_LOAD;
            B_EMIT:  if (i_out_ready && r_idx == DIGEST_LAST) n_state = B_LOAD;
            default: n_state = B_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        o_pop       = (r_state == B_LOAD) && !i_qstat.empty;
        w_round     = o_pop || (r_state == B_ROUND);
        o_out_valid = (r_state == B_EMIT);
        w_out_acc   = o_out_valid && i_out_ready;
        o_out_data.digest_word = r_hash[r_idx];
        o_out_data.word_index  = r_idx;
        o_out_data.last_word   = (r_idx == DIGEST_LAST);
    end

    // round datapath
    always_comb begin
        w_a = (r_t == '0) ? r_hash[0] : r_work[0];
        w_b = (r_t == '0) ? r_hash[1] : r_work[1];
        w_c = (r_t == '0) ? r_hash[2] : r_work[2];
        w_d = (r_t == '0) ? r_hash[3] : r_work[3];
        w_e = (r_t == '0) ? r_hash[4] : r_work[4];
        w_x = r_sched[13] ^ r_sched[8] ^ r_sched[2] ^ r_sched[0];
        w_w = (r_state == B_LOAD) ? i_head.word : {w_x[30:0], w_x[31]};
        priority if (r_t < 7'd20) begin
            w_f = w_d ^ (w_b & (w_c ^ w_d));
            w_k = K_R0;
        end else if (r_t < 7'd40) begin
            w_f = w_b ^ w_c ^ w_d;
            w_k = K_R1;
        end else if (r_t < 7'd60) begin
            w_f = (w_b & w_c) | (w_d & (w_b | w_c));
            w_k = K_R2;
        end else begin
            w_f = w_b ^ w_c ^ w_d;
            w_k = K_R3;
        end
        w_tmp = {w_a[26:0], w_a[31:27]} + w_f + w_e + w_k + w_w;
    end

    always_ff @(posedge i_clk) begin
        if (w_round) begin
            r_work[0] <= w_tmp;
            r_work[1] <= w_a;
            r_work[2] <= {w_b[1:0], w_b[31:2]};
            r_work[3] <= w_c;
            r_work[4] <= w_d;
            for (int i = 0; i < 15; i++) r_sched[i] <= r_sched[i+1];
            r_sched[15] <= w_w;
        end
        if (o_pop) r_fin <= i_head.last;
        if (!i_rst_n) begin
            r_state <= B_LOAD;
            r_t     <= '0;
            r_idx   <= '0;
            for (int i = 0; i < 5; i++) r_hash[i] <= H_INIT[i];
        end else begin
            r_state <= n_state;
            if (w_round) r_t <= (r_t == ROUND_LAST) ? '0 : r_t + 7'd1;
            if (r_state == B_ADD) begin
                for (int i = 0; i < 5; i++) r_hash[i] <= r_hash[i] + r_work[i];
            end
            if (w_out_acc) begin
                if (r_idx == DIGEST_LAST) begin
                    r_idx <= '0;
                    for (int i = 0; i < 5; i++) r_hash[i] <= H_INIT[i];
                end else begin
                    r_idx <= r_idx + 3'd1;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/sha1_stream_hash_core.sv =====
// Top level of the streaming SHA-1 hash core.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one beat per item, carrying an
// optional message byte and an end-of-message mark. Outside padding, the front end takes
// one beat per cycle while the word queue has room and packs bytes into big-endian
// 32-bit words. The compression engine runs one round per cycle: rounds 0-15 consume
// queued words as they arrive, rounds 16-79 run on the rolling schedule, then an add
// state adds the working words into the hash words. The 16-word queue lets the next
// block fill during rounds 16-79, so input need not wait for a block to finish.
// At end of message the front end writes padding and length words, which adds one or
// two blocks; the five digest words then appear on the output channel (o_out_valid /
// i_out_ready / o_out_data), most significant first, one per cycle when not stalled.
// While the receiver stalls, the engine holds the current word and the front end keeps
// filling the queue until it is full. Reset (synchronous, active low) loads the initial
// hash values, clears the byte count and empties the queue; no clearing pass is needed.
module sha1_stream_hash_core
    import sha1sh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_qpush  w_push;
    t_qentry w_head;
    t_qstat  w_qstat;
    logic    w_pop;

    sha1sh_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_qstat    (w_qstat),
        .o_push     (w_push)
    );

    sha1sh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    sha1sh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_qstat     (w_qstat),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid |-> !w_qstat.full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("pop from empty queue");

    a_digest_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_data.last_word) |=> !o_out_valid)
        else $error("digest continues after last word");

    a_digest_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out_data.last_word) |=>
        (o_out_valid && o_out_data.word_index == $past(o_out_data.word_index) + 3'd1))
        else $error("digest word order broken");

endmodule
